@@ hw/rtl/hlq_pkg.sv @@
// ============================================================================
// hlq_pkg
// Shared types and constants for the hysteresis level quantizer.
// ============================================================================
package hlq_pkg;

    // Field and register widths
    localparam int SAMPLE_BITS = 12;
    localparam int SPAN_W      = 13;
    localparam int COUNT_W     = 9;
    localparam int MARGIN_W    = 8;
    localparam int LEVEL_W     = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;

    // Divider: dividends reach 8191*256, so 21 quotient bits
    localparam int DIV_BITS    = 21;
    localparam int REM_W       = SPAN_W;
    localparam int DIV_CNT_W   = $clog2(DIV_BITS + 1);

    // Largest usable level count
    localparam logic [COUNT_W-1:0] LEVEL_MAX = 9'd256;

    // Register reset values
    localparam logic [SPAN_W-1:0]   SPAN_RST   = 13'd1024;
    localparam logic [COUNT_W-1:0]  COUNT_RST  = 9'd64;
    localparam logic [MARGIN_W-1:0] MARGIN_RST = 8'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 2'd2;

    // Which quotient the shared divider works on
    typedef enum logic [1:0] {
        DIV_LO,     // floor(span*L/N)
        DIV_HI,     // floor(span*(L+1)/N)
        DIV_Q       // floor(sample*N/span)
    } t_div_sel;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_LO,
        ST_DIV_HI,
        ST_DIV_Q,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic     load;
        logic     div_start;
        t_div_sel div_sel;
        logic     div_step;
        logic     save_lb;
        logic     lvl_update;
        logic     emit;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic out_band;
        logic out_free;
    } t_dp_status;

endpackage

@@ hw/rtl/hlq_sample_if.sv @@
// ============================================================================
// hlq_sample_if
// Input channel: one converter sample per beat.
// ============================================================================
interface hlq_sample_if;
    import hlq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

@@ hw/rtl/hlq_level_if.sv @@
// ============================================================================
// hlq_level_if
// Output channel: one quantized level per beat.
// ============================================================================
interface hlq_level_if;
    import hlq_pkg::*;

    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level;

    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

@@ hw/rtl/hysteresis_level_quantizer.sv @@
// ============================================================================
// hysteresis_level_quantizer
// Maps converter samples onto discrete levels, holding the level until the
// sample leaves the current band widened by a margin.
// ============================================================================
// Usage:
//   i_sample_ch carries one converter sample per beat (valid/ready).
//   o_level_ch returns one level per sample, in order, from an output
//   register, so the next sample is taken while a level waits for the sink.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
//   (0 span, 1 level count, 2 margin); write only while the block is idle.
// Timing:
//   One shared restoring divider, one quotient bit per cycle over 21 bits,
//   sets the rate. Each sample runs two divisions for the band bounds and a
//   third only when the sample leaves the band.
//   The input opens again in the cycle after the level is written to the
//   output register.
// Reset:
//   Synchronous active low; span 1024, level count 64, margin 3, level 0,
//   no level pending. A stalled sink holds the level beat; the block then
//   finishes at most one more sample and waits before writing it out.
// ============================================================================
module hysteresis_level_quantizer
    import hlq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    hlq_sample_if.sink            i_sample_ch,
    hlq_level_if.source           o_level_ch
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;

    assign i_sample_ch.ready = w_in_ready;

    // Sequencer
    hlq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample_ch.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Arithmetic and storage
    hlq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_sample      (i_sample_ch.sample),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_level_valid (o_level_ch.valid),
        .i_level_ready (o_level_ch.ready),
        .o_level       (o_level_ch.level)
    );

`ifndef SYNTHESIS
    // An accepted sample keeps the input closed on the next cycle
    a_accept_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample_ch.valid && w_in_ready) |=> !w_in_ready)
        else $error("input still open after accepting a sample");

    // A started division is never reported done on the next cycle
    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |=> !w_status.div_done)
        else $error("divider reported done right after start");

    // A level is written out only into a free output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!o_level_ch.valid || o_level_ch.ready))
        else $error("level written over a pending beat");
`endif

endmodule

@@ hw/rtl/hlq_ctrl.sv @@
// ============================================================================
// hlq_ctrl
// Sequencer: runs up to three divisions of one sample and hands off the result.
// ============================================================================
module hlq_ctrl
    import hlq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DIV_LO;
            end
            ST_DIV_LO: begin
                if (i_status.div_done) n_state = ST_DIV_HI;
            end
            ST_DIV_HI: begin
                if (i_status.div_done) begin
                    n_state = i_status.out_band ? ST_DIV_Q : ST_EMIT;
                end
            end
            ST_DIV_Q: begin
                if (i_status.div_done) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.div_sel = DIV_LO;
        o_in_ready    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load      = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_LO;
                end
            end
            ST_DIV_LO: begin
                if (i_status.div_done) begin
                    o_cmd.save_lb   = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_HI;
                end else begin
                    o_cmd.div_step  = 1'b1;
                end
            end
            ST_DIV_HI: begin
                if (i_status.div_done) begin
                    if (i_status.out_band) begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = DIV_Q;
                    end
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            ST_DIV_Q: begin
                if (i_status.div_done) begin
                    o_cmd.lvl_update = 1'b1;
                end else begin
                    o_cmd.div_step   = 1'b1;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) o_cmd.emit = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

@@ hw/rtl/hlq_dp.sv @@
// ============================================================================
// hlq_dp
// Datapath: config registers, band bounds, shared restoring divider,
// held level and output register.
// ============================================================================
module hlq_dp
    import hlq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status,
    output logic                   o_level_valid,
    input  logic                   i_level_ready,
    output logic [LEVEL_W-1:0]     o_level
);

    logic [SPAN_W-1:0]      r_span;
    logic [COUNT_W-1:0]     r_count;
    logic [MARGIN_W-1:0]    r_margin;
    logic [SAMPLE_BITS-1:0] r_samp;
    logic [LEVEL_W-1:0]     r_lvl;
    logic [DIV_BITS-1:0]    r_lb;
    logic [DIV_BITS-1:0]    r_dvd;
    logic [DIV_BITS-1:0]    r_quo;
    logic [REM_W-1:0]       r_rem;
    logic [SPAN_W-1:0]      r_dvs;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic                   r_out_valid;
    logic [LEVEL_W-1:0]     r_out_level;

    logic [SPAN_W-1:0]      w_span_eff;
    logic [COUNT_W-1:0]     w_cnt_eff;
    logic [SPAN_W-1:0]      w_mul_a;
    logic [COUNT_W-1:0]     w_mul_b;
    logic [SPAN_W-1:0]      w_divisor;
    logic [SPAN_W+COUNT_W-1:0] w_prod;
    logic [REM_W:0]         w_shift;
    logic [REM_W-1:0]       w_diff;
    logic                   w_ge;
    logic [DIV_BITS-1:0]    w_lb;
    logic [DIV_BITS:0]      w_ub_excl;
    logic [COUNT_W-1:0]     w_q_sat;
    logic                   w_out_free;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span   <= SPAN_RST;
            r_count  <= COUNT_RST;
            r_margin <= MARGIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SPAN:   r_span   <= i_cfg_data;
                CFG_COUNT:  r_count  <= i_cfg_data[COUNT_W-1:0];
                CFG_MARGIN: r_margin <= i_cfg_data[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp span and level count into their usable ranges
    assign w_span_eff = (r_span == '0) ? SPAN_W'(1) : r_span;
    always_comb begin
        if (r_count == '0) begin
            w_cnt_eff = COUNT_W'(1);
        end else if (r_count > LEVEL_MAX) begin
            w_cnt_eff = LEVEL_MAX;
        end else begin
            w_cnt_eff = r_count;
        end
    end

    // Pick the product and divisor for the division being started
    always_comb begin
        case (i_cmd.div_sel)
            DIV_HI: begin
                w_mul_a   = w_span_eff;
                w_mul_b   = {1'b0, r_lvl} + COUNT_W'(1);
                w_divisor = {{(SPAN_W-COUNT_W){1'b0}}, w_cnt_eff};
            end
            DIV_Q: begin
                w_mul_a   = {{(SPAN_W-SAMPLE_BITS){1'b0}}, r_samp};
                w_mul_b   = w_cnt_eff;
                w_divisor = w_span_eff;
            end
            default: begin
                w_mul_a   = w_span_eff;
                w_mul_b   = {1'b0, r_lvl};
                w_divisor = {{(SPAN_W-COUNT_W){1'b0}}, w_cnt_eff};
            end
        endcase
    end

    assign w_prod = {{COUNT_W{1'b0}}, w_mul_a} * {{SPAN_W{1'b0}}, w_mul_b};

    // One quotient bit per step; remainder stays below the divisor
    assign w_shift = {r_rem, r_dvd[DIV_BITS-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});
    assign w_diff  = w_shift[REM_W-1:0] - r_dvs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_cnt <= DIV_CNT_W'(DIV_BITS);
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dvd <= w_prod[DIV_BITS-1:0];
            r_rem <= '0;
            r_quo <= '0;
            r_dvs <= w_divisor;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[DIV_BITS-2:0], 1'b0};
            r_rem <= w_ge ? w_diff : w_shift[REM_W-1:0];
            r_quo <= {r_quo[DIV_BITS-2:0], w_ge};
        end
    end

    // Capture the sample of the accepted beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_samp <= i_sample;
    end

    // Lower bound: widen by the margin except at level zero, floor at zero
    always_comb begin
        if (r_lvl == '0) begin
            w_lb = r_quo;
        end else if (r_quo >= DIV_BITS'(r_margin)) begin
            w_lb = r_quo - DIV_BITS'(r_margin);
        end else begin
            w_lb = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.save_lb) r_lb <= w_lb;
    end

    // Upper bound kept exclusive so it never goes negative
    assign w_ub_excl = {1'b0, r_quo} + (DIV_BITS+1)'(r_margin);

    // Saturate the new level to N-1
    assign w_q_sat = (r_quo >= DIV_BITS'(w_cnt_eff)) ? (w_cnt_eff - COUNT_W'(1))
                                                      : r_quo[COUNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl <= '0;
        end else if (i_cmd.lvl_update) begin
            r_lvl <= w_q_sat[LEVEL_W-1:0];
        end
    end

    // Output register: hold the level until the sink takes the beat
    assign w_out_free = !r_out_valid || i_level_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_level_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) r_out_level <= r_lvl;
    end

    assign o_status.div_done = (r_cnt == '0);
    assign o_status.out_band = (DIV_BITS'(r_samp) < r_lb) ||
                               ((DIV_BITS+1)'(r_samp) >= w_ub_excl);
    assign o_status.out_free = w_out_free;

    assign o_level_valid = r_out_valid;
    assign o_level       = r_out_level;

endmodule

@@ tb/sv/hysteresis_level_quantizer_tb.sv @@
// ============================================================================
// hysteresis_level_quantizer_tb
// Self-checking bench for the hysteresis level quantizer. Sample beats come
// from a queue filled by the stimulus process. Each accepted beat is run
// through a local copy of the band and quantize rules to get the level
// that should come back. Returned levels are compared in order. Register
// settings change only between phases, once every level has returned.
// ============================================================================
module hysteresis_level_quantizer_tb;
    import hlq_pkg::*;

    localparam int RANDOM_ITEMS = 1000;
    localparam int LONG_STALL   = 300;
    localparam int SETTLE_CYCLES = 80;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    hlq_sample_if sample_ch ();
    hlq_level_if  level_ch ();

    hysteresis_level_quantizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_sample_ch (sample_ch),
        .o_level_ch  (level_ch)
    );

    // Local copy of the registers and the held level
    logic [SPAN_W-1:0]   span_r;
    logic [COUNT_W-1:0]  count_r;
    logic [MARGIN_W-1:0] margin_r;
    logic [LEVEL_W-1:0]  held_level;

    logic [SAMPLE_BITS-1:0] sample_q[$];
    logic [LEVEL_W-1:0]     level_q[$];

    int queued_cnt;
    int accepted_cnt;
    int returned_cnt;
    int level_changes;
    int setting_cnt;
    int errors;
    int stall_left;
    bit stall_done;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Level after one sample, given the held level and current registers
    function automatic logic [LEVEL_W-1:0] next_level(input logic [LEVEL_W-1:0] held,
                                                     input logic [SAMPLE_BITS-1:0] smp);
        longint span;
        longint n;
        longint lvl;
        longint lb;
        longint ub;
        longint sv;
        longint q;
        span = (span_r == 0) ? 1 : span_r;
        if (count_r == 0)
            n = 1;
        else if (count_r > LEVEL_MAX)
            n = LEVEL_MAX;
        else
            n = count_r;
        lvl = held;
        sv  = smp;
        // Band of the held level, widened by the margin
        lb = (span * lvl) / n;
        if (lvl > 0)
            lb = lb - margin_r;
        if (lb < 0)
            lb = 0;
        ub = (span * (lvl + 1)) / n - 1 + margin_r;
        // Re-quantize only when the sample leaves the band
        if (sv < lb || sv > ub) begin
            q = (sv * n) / span;
            if (q > n - 1)
                q = n - 1;
            lvl = q;
        end
        return lvl[LEVEL_W-1:0];
    endfunction

    // Mirror register writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            span_r   <= SPAN_RST;
            count_r  <= COUNT_RST;
            margin_r <= MARGIN_RST;
        end else if (cfg_we) begin
            case (cfg_idx)
                CFG_SPAN:   span_r   <= cfg_data[SPAN_W-1:0];
                CFG_COUNT:  count_r  <= cfg_data[COUNT_W-1:0];
                CFG_MARGIN: margin_r <= cfg_data[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Sample driver: predict on each accepted beat, then offer the next one
    always @(posedge i_clk) begin
        logic [LEVEL_W-1:0] nxt;
        bit calm;
        if (!i_rst_n) begin
            sample_ch.valid <= 1'b0;
            held_level = '0;
        end else begin
            if (sample_ch.valid && sample_ch.ready) begin
                nxt = next_level(held_level, sample_ch.sample);
                if (nxt != held_level)
                    level_changes++;
                held_level = nxt;
                level_q.push_back(nxt);
                accepted_cnt <= accepted_cnt + 1;
            end
            calm = accepted_cnt >= 400 && accepted_cnt < 550;
            if (!sample_ch.valid || sample_ch.ready) begin
                if (sample_q.size() != 0 && (calm || $urandom_range(99) >= 21)) begin
                    sample_ch.valid  <= 1'b1;
                    sample_ch.sample <= sample_q.pop_front();
                end else begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Level monitor and receiver backpressure
    always @(posedge i_clk) begin
        logic [LEVEL_W-1:0] want;
        bit calm;
        if (!i_rst_n) begin
            level_ch.ready <= 1'b0;
        end else begin
            if (level_ch.valid && level_ch.ready) begin
                if (level_q.size() == 0) begin
                    $display("%0t: level beat %0d with no sample outstanding",
                             $time, level_ch.level);
                    errors++;
                end else begin
                    want = level_q.pop_front();
                    if (level_ch.level !== want) begin
                        $display("%0t: level mismatch: expected %0d, got %0d",
                                 $time, want, level_ch.level);
                        errors++;
                    end
                end
                returned_cnt <= returned_cnt + 1;
            end
            calm = returned_cnt >= 400 && returned_cnt < 550;
            // Hold off once for a long stretch so the input backs up
            if (stall_left != 0) begin
                level_ch.ready <= 1'b0;
                stall_left     <= stall_left - 1;
            end else if (!stall_done && returned_cnt >= 200) begin
                level_ch.ready <= 1'b0;
                stall_left     <= LONG_STALL;
                stall_done     <= 1'b1;
            end else begin
                level_ch.ready <= calm || $urandom_range(99) >= 21;
            end
        end
    end

    task automatic add_sample(input logic [SAMPLE_BITS-1:0] smp);
        sample_q.push_back(smp);
        queued_cnt++;
    endtask

    // Wait until every queued sample has returned its level
    task automatic drain();
        while (accepted_cnt != queued_cnt || returned_cnt != accepted_cnt)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
    endtask

    // Write all three registers while the block is idle
    task automatic set_regs(input int span, input int count, input int mrg);
        drain();
        write_reg(CFG_SPAN, span);
        write_reg(CFG_COUNT, count);
        write_reg(CFG_MARGIN, mrg);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        setting_cnt++;
    endtask

    // Stimulus
    initial begin
        int done_random;
        int phase_len;
        int span;
        int count;
        int mrg;
        int eff_span;
        int eff_count;
        int step;
        int walk;
        int r;

        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = CFG_SPAN;
        cfg_data         = '0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        level_ch.ready   = 1'b0;
        queued_cnt       = 0;
        accepted_cnt     = 0;
        returned_cnt     = 0;
        level_changes    = 0;
        setting_cnt      = 1;
        errors           = 0;
        stall_left       = 0;
        stall_done       = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: edges of the range, hold inside the margin
        add_sample(12'd0);
        add_sample(12'd4095);
        add_sample(12'd1020);
        add_sample(12'd1005);
        add_sample(12'd1004);
        add_sample(12'd16);
        add_sample(12'd12);
        add_sample(12'd1023);
        add_sample(12'd1024);

        // Zero span and zero level count
        set_regs(0, 0, 0);
        add_sample(12'd0);
        add_sample(12'd4095);
        add_sample(12'd7);

        // Full span, count above the maximum, widest margin
        set_regs(4096, 511, 255);
        add_sample(12'd0);
        add_sample(12'd2048);
        add_sample(12'd4095);

        // Held level far above the new level count
        set_regs(4096, 4, 0);
        add_sample(12'd4000);
        add_sample(12'd100);

        // Span below level count: upper bound goes negative
        set_regs(1, 256, 0);
        add_sample(12'd0);
        add_sample(12'd1);
        add_sample(12'd4095);

        // Random phases, each with its own settings
        done_random = 0;
        while (done_random < RANDOM_ITEMS) begin
            r = $urandom_range(9);
            case (r)
                0:       span = 1;
                1:       span = 4096;
                2:       span = 0;
                3:       span = $urandom_range(8191, 4097);
                default: span = $urandom_range(4096, 2);
            endcase
            r = $urandom_range(9);
            case (r)
                0:       count = 1;
                1:       count = 256;
                2:       count = 0;
                3:       count = $urandom_range(511, 257);
                default: count = $urandom_range(255, 2);
            endcase
            r = $urandom_range(9);
            case (r)
                0:       mrg = 0;
                1:       mrg = 255;
                2, 3, 4: mrg = $urandom_range(16);
                default: mrg = $urandom_range(254, 1);
            endcase
            set_regs(span, count, mrg);

            eff_span  = (span == 0) ? 1 : span;
            eff_count = (count == 0) ? 1 : ((count > 256) ? 256 : count);
            step      = mrg + eff_span / eff_count + 1;
            walk      = $urandom_range(eff_span > 4096 ? 4095 : eff_span - 1);
            phase_len = $urandom_range(100, 50);
            // Mostly a random walk around the band edges, some jumps
            repeat (phase_len) begin
                r = $urandom_range(99);
                if (r < 15) begin
                    add_sample(SAMPLE_BITS'($urandom_range(4095)));
                end else if (r < 22) begin
                    case ($urandom_range(3))
                        0:       add_sample(12'd0);
                        1:       add_sample(12'd4095);
                        2:       add_sample(eff_span > 4096 ? 12'd4095
                                                            : SAMPLE_BITS'(eff_span - 1));
                        default: add_sample(eff_span > 4095 ? 12'd4095
                                                            : SAMPLE_BITS'(eff_span));
                    endcase
                end else begin
                    walk = walk + $urandom_range(2 * step) - step;
                    if (walk < 0)
                        walk = 0;
                    if (walk > 4095)
                        walk = 4095;
                    add_sample(walk[SAMPLE_BITS-1:0]);
                end
            end
            done_random += phase_len;
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (level_q.size() != 0) begin
            $display("%0t: %0d levels never returned", $time, level_q.size());
            errors++;
        end

        $display("Ran %0d samples over %0d register settings, %0d level changes,",
                 returned_cnt, setting_cnt, level_changes);
        $display("with random gaps on both sides and one long output stall.");
        if (errors == 0)
            $display("hysteresis_level_quantizer verification clean");
        else
            $display("hysteresis_level_quantizer verification failed");
        $finish;
    end

    // Watchdog
    initial begin
        #3000000;
        $display("hysteresis_level_quantizer verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/hlq_pkg.sv
hw/rtl/hlq_sample_if.sv
hw/rtl/hlq_level_if.sv
hw/rtl/hlq_ctrl.sv
hw/rtl/hlq_dp.sv
hw/rtl/hysteresis_level_quantizer.sv
tb/sv/hysteresis_level_quantizer_tb.sv
